### hdl/mtirp_pkg.sv
package mtirp_pkg;

   localparam int unsigned MAX_REGISTERS = 125;

   localparam int unsigned POS_W = 9;
   localparam logic [POS_W-1:0] POS_MAX      = 9'd511;
   localparam logic [POS_W-1:0] HDR_LEN      = 9'd9;
   localparam logic [POS_W-1:0] POS_TID_HI   = 9'd0;
   localparam logic [POS_W-1:0] POS_TID_LO   = 9'd1;
   localparam logic [POS_W-1:0] POS_PROTO_HI = 9'd2;
   localparam logic [POS_W-1:0] POS_PROTO_LO = 9'd3;
   localparam logic [POS_W-1:0] POS_LEN_HI   = 9'd4;
   localparam logic [POS_W-1:0] POS_LEN_LO   = 9'd5;
   localparam logic [POS_W-1:0] POS_UNIT     = 9'd6;
   localparam logic [POS_W-1:0] POS_FUNC     = 9'd7;
   localparam logic [POS_W-1:0] POS_BCNT     = 9'd8;

   localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
   localparam logic [7:0] PROTO_ID        = 8'h00;

   // check flag bit positions
   localparam int unsigned FL_TID   = 0;
   localparam int unsigned FL_PROTO = 1;
   localparam int unsigned FL_UNIT  = 2;
   localparam int unsigned FL_FUNC  = 3;
   localparam int unsigned FL_BCNT  = 4;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_LENGTH   = 3'd1;
   localparam logic [2:0] STATUS_TID      = 3'd2;
   localparam logic [2:0] STATUS_PROTO    = 3'd3;
   localparam logic [2:0] STATUS_UNIT     = 3'd4;
   localparam logic [2:0] STATUS_FUNC     = 3'd5;
   localparam logic [2:0] STATUS_BYTE_CNT = 3'd6;

   localparam logic [1:0] CSR_TXN_ID         = 2'd0;
   localparam logic [1:0] CSR_UNIT_ID        = 2'd1;
   localparam logic [1:0] CSR_REGISTER_COUNT = 2'd2;

   typedef struct packed {
      logic        reg_valid;
      logic [6:0]  reg_index;
      logic [15:0] reg_value;
      logic        frame_done;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [15:0] txn_id;
      logic [7:0]  unit_id;
      logic [6:0]  register_count;
   } cfg_type;

endpackage

### hdl/modbus_tcp_input_reg_response_parser_core.sv
// Channel   Dir  Handshake            Payload
// req       in   req_valid/req_ready  req_frame_byte[7:0], req_last_byte
// rsp       out  rsp_valid/rsp_ready  rsp_reg_valid, rsp_reg_index[6:0],
//                                     rsp_reg_value[15:0], rsp_frame_done, rsp_status[2:0]
// csr       in   csr_we               csr_index[1:0], csr_wdata[15:0]
//
// One byte per cycle while req_ready is high: header checks and register assembly are one compare stage
// between the frame state registers and the result register.
// A result is registered in the output register, or in the skid register while the output is held;
// beats that complete no register and are not last give none.
// A two-deep result buffer keeps req_ready high while one result waits; it drops
// only when both entries are held.
// Synchronous reset clears frame state and the configuration (register count 1).
module modbus_tcp_input_reg_response_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reg_valid,
   output logic [6:0]  rsp_reg_index,
   output logic [15:0] rsp_reg_value,
   output logic        rsp_frame_done,
   output logic [2:0]  rsp_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import mtirp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    accept;
   logic    has_result;
   rsp_type result;
   rsp_type out_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TXN_ID:         cfg_in.txn_id         = csr_wdata;
            CSR_UNIT_ID:        cfg_in.unit_id        = csr_wdata[7:0];
            CSR_REGISTER_COUNT: cfg_in.register_count = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.txn_id         <= '0;
         cfg_ff.unit_id        <= '0;
         cfg_ff.register_count <= 7'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = req_valid & req_ready;

   mtirp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .frame_byte (req_frame_byte),
      .last_byte  (req_last_byte),
      .cfg        (cfg_ff),
      .has_result (has_result),
      .result     (result)
   );

   mtirp_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (accept & has_result),
      .push_data  (result),
      .can_accept (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_reg_valid  = out_data.reg_valid;
   assign rsp_reg_index  = out_data.reg_index;
   assign rsp_reg_value  = out_data.reg_value;
   assign rsp_frame_done = out_data.frame_done;
   assign rsp_status     = out_data.status;

   // a result beat always carries a register or a frame end
   a_rsp_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reg_valid || rsp_frame_done))
      else $error("empty result beat");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_done) |-> (rsp_status == STATUS_OK))
      else $error("status set before frame end");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reg_valid) |-> (rsp_reg_index < 7'(MAX_REGISTERS)))
      else $error("register index beyond limit");

   // back-pressure only once the output is occupied
   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

endmodule

### hdl/mtirp_parse.sv
module mtirp_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        frame_byte,
   input  logic              last_byte,
   input  mtirp_pkg::cfg_type cfg,
   output logic              has_result,
   output mtirp_pkg::rsp_type result
);
   import mtirp_pkg::*;

   logic [POS_W-1:0] byte_position_ff, byte_position_in;
   logic [7:0]       tid_high_byte_ff, tid_high_byte_in;
   logic [4:0]       check_flags_ff, check_flags_in;
   logic [7:0]       received_byte_count_ff, received_byte_count_in;
   logic [7:0]       data_high_byte_ff, data_high_byte_in;

   logic [POS_W-1:0] pos_next;
   logic [POS_W-1:0] offset;
   logic [7:0]       reg_k;
   logic [6:0]       limit;
   logic [POS_W-1:0] want_len;
   logic [4:0]       flags_now;
   logic [7:0]       bcnt_now;
   logic [2:0]       status;

   assign limit = (cfg.register_count > 7'(MAX_REGISTERS)) ? 7'(MAX_REGISTERS)
                                                          : cfg.register_count;
   assign offset = byte_position_ff - HDR_LEN;
   assign reg_k  = offset[POS_W-1:1];
   assign pos_next = (byte_position_ff != POS_MAX) ? byte_position_ff + 9'd1
                                                   : byte_position_ff;

   always_comb begin
      tid_high_byte_in       = tid_high_byte_ff;
      flags_now              = check_flags_ff;
      bcnt_now               = received_byte_count_ff;
      data_high_byte_in      = data_high_byte_ff;
      result                 = '0;
      case (byte_position_ff)
         POS_TID_HI: tid_high_byte_in = frame_byte;
         POS_TID_LO: begin
            if ({tid_high_byte_ff, frame_byte} != cfg.txn_id)
               flags_now[FL_TID] = 1'b1;
         end
         POS_PROTO_HI, POS_PROTO_LO: begin
            if (frame_byte != PROTO_ID) flags_now[FL_PROTO] = 1'b1;
         end
         POS_LEN_HI, POS_LEN_LO: ;
         POS_UNIT: begin
            if (frame_byte != cfg.unit_id) flags_now[FL_UNIT] = 1'b1;
         end
         POS_FUNC: begin
            if (frame_byte != FUNC_READ_INPUT) flags_now[FL_FUNC] = 1'b1;
         end
         POS_BCNT: begin
            bcnt_now = frame_byte;
            if (frame_byte != {cfg.register_count, 1'b0}) flags_now[FL_BCNT] = 1'b1;
         end
         default: begin
            if (byte_position_ff != POS_MAX) begin
               if (!offset[0]) begin
                  data_high_byte_in = frame_byte;
               end else if (reg_k < {1'b0, limit}) begin
                  result.reg_valid = 1'b1;
                  result.reg_index = reg_k[6:0];
                  result.reg_value = {data_high_byte_ff, frame_byte};
               end
            end
         end
      endcase

      // status uses the length including this beat
      want_len = HDR_LEN + {1'b0, bcnt_now};
      if (pos_next < HDR_LEN)         status = STATUS_LENGTH;
      else if (flags_now[FL_TID])     status = STATUS_TID;
      else if (flags_now[FL_PROTO])   status = STATUS_PROTO;
      else if (flags_now[FL_UNIT])    status = STATUS_UNIT;
      else if (flags_now[FL_FUNC])    status = STATUS_FUNC;
      else if (flags_now[FL_BCNT])    status = STATUS_BYTE_CNT;
      else if (pos_next != want_len)  status = STATUS_LENGTH;
      else                            status = STATUS_OK;

      if (last_byte) begin
         result.frame_done      = 1'b1;
         result.status          = status;
         byte_position_in       = '0;
         tid_high_byte_in       = '0;
         check_flags_in         = '0;
         received_byte_count_in = '0;
         data_high_byte_in      = '0;
      end else begin
         byte_position_in       = pos_next;
         check_flags_in         = flags_now;
         received_byte_count_in = bcnt_now;
      end
      has_result = result.reg_valid | last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff       <= '0;
         tid_high_byte_ff       <= '0;
         check_flags_ff         <= '0;
         received_byte_count_ff <= '0;
         data_high_byte_ff      <= '0;
      end else if (accept) begin
         byte_position_ff       <= byte_position_in;
         tid_high_byte_ff       <= tid_high_byte_in;
         check_flags_ff         <= check_flags_in;
         received_byte_count_ff <= received_byte_count_in;
         data_high_byte_ff      <= data_high_byte_in;
      end
   end

endmodule

### hdl/mtirp_skid.sv
module mtirp_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mtirp_pkg::rsp_type push_data,
   output logic              can_accept,
   output logic              out_valid,
   input  logic              out_ready,
   output mtirp_pkg::rsp_type out_data
);
   import mtirp_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   assign out_free   = out_ready | ~out_valid_ff;
   assign can_accept = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         // no push while skid holds a beat
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

### tb/mtirp_frame_check.sv
module mtirp_frame_check
   import mtirp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_reg_valid,
   input  logic [6:0]  rsp_reg_index,
   input  logic [15:0] rsp_reg_value,
   input  logic        rsp_frame_done,
   input  logic [2:0]  rsp_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type          cfg;
   logic [POS_W-1:0] byte_pos;
   logic [7:0]       tid_hi;
   logic [7:0]       rx_bcnt;
   logic [7:0]       data_hi;
   logic [4:0]       flags;
   rsp_type          parsed_results[$];
   rsp_type          seen;
   rsp_type          oldest;
   rsp_type          fresh;

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("%0t ns: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
      fail_count++;
   endtask

   task automatic compare_field(input string what, input int unsigned want,
                                input int unsigned got);
      if (want != got) report_mismatch(what, want, got);
   endtask

   function automatic logic [2:0] frame_status(input logic [POS_W-1:0] len);
      if (len < HDR_LEN)                             return STATUS_LENGTH;
      if (flags[FL_TID])                             return STATUS_TID;
      if (flags[FL_PROTO])                           return STATUS_PROTO;
      if (flags[FL_UNIT])                            return STATUS_UNIT;
      if (flags[FL_FUNC])                            return STATUS_FUNC;
      if (flags[FL_BCNT])                            return STATUS_BYTE_CNT;
      if (int'(len) != int'(HDR_LEN) + int'(rx_bcnt)) return STATUS_LENGTH;
      return STATUS_OK;
   endfunction

   // advances the frame state by one byte; returns 1 when the byte yields a result
   function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                     output rsp_type r);
      logic [POS_W-1:0] p;
      int unsigned      lim;
      int unsigned      off;
      int unsigned      k;
      bit               got;
      p   = byte_pos;
      r   = '0;
      got = 1'b0;
      lim = (cfg.register_count > MAX_REGISTERS) ? MAX_REGISTERS : cfg.register_count;
      case (p)
         POS_TID_HI: tid_hi = b;
         POS_TID_LO: if ({tid_hi, b} != cfg.txn_id) flags[FL_TID] = 1'b1;
         POS_PROTO_HI, POS_PROTO_LO: if (b != PROTO_ID) flags[FL_PROTO] = 1'b1;
         POS_LEN_HI, POS_LEN_LO: ;
         POS_UNIT: if (b != cfg.unit_id) flags[FL_UNIT] = 1'b1;
         POS_FUNC: if (b != FUNC_READ_INPUT) flags[FL_FUNC] = 1'b1;
         POS_BCNT: begin
            rx_bcnt = b;
            if (int'(b) != 2 * int'(cfg.register_count)) flags[FL_BCNT] = 1'b1;
         end
         default: begin
            if (p < POS_MAX) begin
               off = p - HDR_LEN;
               k   = off / 2;
               if (off % 2 == 0) begin
                  data_hi = b;
               end else if (k < lim && k < cfg.register_count) begin
                  r.reg_valid = 1'b1;
                  r.reg_index = k[6:0];
                  r.reg_value = {data_hi, b};
                  got         = 1'b1;
               end
            end
         end
      endcase
      if (p < POS_MAX) byte_pos = p + 1'b1;
      if (last) begin
         r.frame_done = 1'b1;
         r.status     = frame_status(byte_pos);
         got          = 1'b1;
         byte_pos     = '0;
         tid_hi       = '0;
         flags        = '0;
         rx_bcnt      = '0;
         data_hi      = '0;
      end
      return got;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg         = '{txn_id: 16'h0000, unit_id: 8'h00, register_count: 7'd1};
         byte_pos    = '0;
         tid_hi      = '0;
         flags       = '0;
         rx_bcnt     = '0;
         data_hi     = '0;
         fail_count  = 0;
         parsed_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_reg_valid, rsp_reg_index, rsp_reg_value, rsp_frame_done, rsp_status};
            if (parsed_results.size() == 0) begin
               report_mismatch("unexpected result beat", 0, seen);
            end else begin
               oldest = parsed_results.pop_front();
               compare_field("reg_valid", oldest.reg_valid, seen.reg_valid);
               compare_field("reg_index", oldest.reg_index, seen.reg_index);
               compare_field("reg_value", oldest.reg_value, seen.reg_value);
               compare_field("frame_done", oldest.frame_done, seen.frame_done);
               compare_field("status", oldest.status, seen.status);
            end
         end
         // a byte in the same beat as a register write still sees the old value
         if (req_valid && req_ready) begin
            if (parse_byte(req_frame_byte, req_last_byte, fresh))
               parsed_results.push_back(fresh);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TXN_ID:         cfg.txn_id         = csr_wdata;
               CSR_UNIT_ID:        cfg.unit_id        = csr_wdata[7:0];
               CSR_REGISTER_COUNT: cfg.register_count = csr_wdata[6:0];
               default: ;
            endcase
         end
      end
      outstanding = parsed_results.size();
   end

endmodule

### tb/tb_modbus_tcp_input_reg_response_parser_core.sv
module tb_modbus_tcp_input_reg_response_parser_core;
   import mtirp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;
   localparam int BYTE_TARGET = 1450;

   // header corruption mask bits
   localparam int ERR_TID      = 1;
   localparam int ERR_PROTO_HI = 2;
   localparam int ERR_PROTO_LO = 4;
   localparam int ERR_UNIT     = 8;
   localparam int ERR_FUNC     = 16;
   localparam int ERR_BCNT     = 32;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_frame_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_reg_valid;
   logic [6:0]  rsp_reg_index;
   logic [15:0] rsp_reg_value;
   logic        rsp_frame_done;
   logic [2:0]  rsp_status;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   int          fail_count;
   int          outstanding;

   logic [7:0]  frame_q[$];
   int          burst_left;
   int          bytes_sent;
   int          quiet_cycles;
   rx_mode_type rx_mode;
   int          rx_left;
   int          rx_hold;

   modbus_tcp_input_reg_response_parser_core DUT (.*);

   mtirp_frame_check u_frame_check (.*);

   always #5 clock = ~clock;

   // result side back-pressure, switching between stall patterns
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_mode)
         RX_OPEN:  rsp_ready <= 1'b1;
         RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_HEAVY: rsp_ready <= ($urandom_range(0, 5) == 0);
         default: begin
            if (rx_hold == 0) begin
               rsp_ready <= ~rsp_ready;
               rx_hold = $urandom_range(1, 15);
            end
            rx_hold--;
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 12);
      end
      req_valid      <= 1'b1;
      req_frame_byte <= b;
      req_last_byte  <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // upper write-data bits are junk on purpose
   task automatic load_config(input cfg_type c);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_TXN_ID;
      csr_wdata <= c.txn_id;
      @(negedge clock);
      csr_index <= CSR_UNIT_ID;
      csr_wdata <= {8'($urandom), c.unit_id};
      @(negedge clock);
      csr_index <= CSR_REGISTER_COUNT;
      csr_wdata <= {9'($urandom), c.register_count};
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [7:0] nonzero_byte();
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic make_frame(input cfg_type c, input int errs);
      logic [15:0] tid;
      logic [15:0] len;
      logic [7:0]  bcnt;
      frame_q.delete();
      tid = c.txn_id;
      if ((errs & ERR_TID) != 0) tid ^= 16'($urandom_range(1, 65535));
      frame_q.push_back(tid[15:8]);
      frame_q.push_back(tid[7:0]);
      frame_q.push_back(((errs & ERR_PROTO_HI) != 0) ? nonzero_byte() : PROTO_ID);
      frame_q.push_back(((errs & ERR_PROTO_LO) != 0) ? nonzero_byte() : PROTO_ID);
      // MBAP length is not checked: sometimes right, sometimes junk
      len = ($urandom_range(0, 1) != 0) ? 16'(3 + 2 * c.register_count) : 16'($urandom);
      frame_q.push_back(len[15:8]);
      frame_q.push_back(len[7:0]);
      frame_q.push_back(((errs & ERR_UNIT) != 0) ? c.unit_id ^ nonzero_byte() : c.unit_id);
      frame_q.push_back(((errs & ERR_FUNC) != 0) ? FUNC_READ_INPUT ^ nonzero_byte()
                                                 : FUNC_READ_INPUT);
      bcnt = 8'(2 * c.register_count);
      if ((errs & ERR_BCNT) != 0) bcnt ^= nonzero_byte();
      frame_q.push_back(bcnt);
      repeat (2 * c.register_count) frame_q.push_back(8'($urandom));
   endtask

   task automatic random_frame(input cfg_type c);
      int kind;
      int cut;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         frame_q.delete();
         repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom));
      end else begin
         make_frame(c, (kind >= 60 && kind < 80) ? $urandom_range(1, 63) : 0);
         if (kind >= 80 && kind < 90) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
         end else if (kind >= 90) begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
         end
      end
      send_frame();
   endtask

   function automatic cfg_type pick_config(input int phase);
      cfg_type c;
      int      r;
      r = $urandom_range(0, 9);
      c.txn_id = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
      r = $urandom_range(0, 9);
      c.unit_id = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
      r = $urandom_range(0, 99);
      c.register_count = (r < 65) ? 7'($urandom_range(0, 4))
                       : (r < 93) ? 7'($urandom_range(5, 16))
                       : 7'($urandom_range(120, 127));
      case (phase)
         0: c = '{txn_id: 16'hFFFF, unit_id: 8'hFF, register_count: 7'd127};
         1: c = '{txn_id: 16'h0000, unit_id: 8'h00, register_count: 7'd0};
         2: c.register_count = 7'd126;
         3: c.register_count = 7'($urandom_range(1, 3));
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      cfg_type cfg_now;
      int      phase;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_frame_byte <= 8'h00;
      req_last_byte  <= 1'b0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_TXN_ID;
      csr_wdata      <= 16'h0000;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: id 0, unit 0, one register
      frame_q = '{8'h00, 8'h00, PROTO_ID, PROTO_ID, 8'h00, 8'h05, 8'h00,
                  FUNC_READ_INPUT, 8'h02, 8'hFF, 8'hFF};
      send_frame();
      frame_q = '{8'hFF};
      send_frame();
      // header only, byte count 0 while one register is expected
      frame_q = '{8'h00, 8'h00, PROTO_ID, PROTO_ID, 8'h00, 8'h03, 8'h00,
                  FUNC_READ_INPUT, 8'h00};
      send_frame();

      for (phase = 0; phase < 4 || bytes_sent < BYTE_TARGET; phase++) begin
         cfg_now = pick_config(phase);
         load_config(cfg_now);
         if (phase < 3) begin
            make_frame(cfg_now, 0);
            send_frame();
         end else if (phase == 3) begin
            // runs the position counter into saturation
            make_frame(cfg_now, 0);
            while (frame_q.size() < 520) frame_q.push_back(8'($urandom));
            send_frame();
         end
         // from phase 3 on, each phase adds one to four random frames
         if (phase >= 3) repeat ($urandom_range(1, 4)) random_frame(cfg_now);
      end

      settle();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
